// File: src/rdm_pkg.sv
// Types and constants shared by the ramp dimmer files.
`timescale 1ns / 1ps
package rdm_pkg;

  localparam int unsigned LVL_W = 8;
  localparam int unsigned OP_W = 4;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [LVL_W-1:0] LEVEL_MAX = 8'hFF;
  localparam logic [LVL_W-1:0] LEVEL_ZERO = 8'h00;
  localparam logic [LVL_W-1:0] LEVEL_ONE = 8'h01;
  localparam logic [LVL_W-1:0] RAMP_STEP_RST = 8'h05;

  localparam logic [CFG_IDX_W-1:0] REG_LAMP_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 4'd1;

  localparam logic LAMP_ONOFF    = 1'b0;
  localparam logic LAMP_DIMMABLE = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 4'd0,
    OP_TOGGLE    = 4'd1,
    OP_MAX       = 4'd2,
    OP_DIM_START = 4'd3,
    OP_DIM_STOP  = 4'd4,
    OP_OFF       = 4'd5,
    OP_ON        = 4'd6,
    OP_SET_LEVEL = 4'd7,
    OP_STORE_MEMO = 4'd8,
    OP_SET_MEMO  = 4'd9
  } op_t;

  typedef struct packed {
    logic             dimmable;
    logic [LVL_W-1:0] ramp_step;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             level_changed;
    logic [LVL_W-1:0] memo_level;
    logic             memo_written;
  } res_t;

endpackage

// File: src/rdm_ifs.sv
// Channel interfaces for commands, results and configuration writes.
`timescale 1ns / 1ps
interface rdm_in_if
  import rdm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [LVL_W-1:0] operand;
  modport source (output valid, opcode, operand, input ready);
  modport sink (input valid, opcode, operand, output ready);
endinterface

interface rdm_out_if
  import rdm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [LVL_W-1:0] level;
  logic             level_changed;
  logic [LVL_W-1:0] memo_level;
  logic             memo_written;
  modport source (output valid, level, level_changed, memo_level, memo_written, input ready);
  modport sink (input valid, level, level_changed, memo_level, memo_written, output ready);
endinterface

interface rdm_cfg_if
  import rdm_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

// File: src/rdm_cfg_regs.sv
// Configuration registers: light type and ramp step.
`timescale 1ns / 1ps
module rdm_cfg_regs
  import rdm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  rdm_cfg_if.sink cfg_ch,
  output cfg_t  cfg
);

  logic             dimmable_r;
  logic [LVL_W-1:0] ramp_step_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dimmable_r  <= LAMP_DIMMABLE;
      ramp_step_r <= RAMP_STEP_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        REG_LAMP_MODE: dimmable_r <= cfg_ch.data[0];
        REG_RAMP_STEP:  ramp_step_r <= cfg_ch.data[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.dimmable  = dimmable_r;
  assign cfg.ramp_step = ramp_step_r;

endmodule

// File: src/rdm_ctrl.sv
// Level, memo and ramp state with the per-command update logic.
`timescale 1ns / 1ps
module rdm_ctrl
  import rdm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             adv,
  input  logic [OP_W-1:0]  opcode,
  input  logic [LVL_W-1:0] operand,
  output res_t             res
);

  logic [LVL_W-1:0] level_r, level_nxt;
  logic [LVL_W-1:0] memo_r, memo_nxt;
  logic             ramping_r, ramping_nxt;
  logic             down_r, down_nxt;
  logic             memo_wr;
  logic             tick_dir;
  logic [LVL_W:0]   up_sum;
  logic [LVL_W-1:0] up_lvl;
  logic [LVL_W-1:0] dn_lvl;
  op_t              op;

  assign op     = op_t'(opcode);
  assign up_sum = {1'b0, level_r} + {1'b0, cfg.ramp_step};
  assign up_lvl = up_sum[LVL_W] ? LEVEL_MAX : up_sum[LVL_W-1:0];
  assign dn_lvl = (level_r >= cfg.ramp_step) ? (level_r - cfg.ramp_step) : LEVEL_ZERO;

  always_comb begin
    if (level_r == LEVEL_MAX) begin
      tick_dir = 1'b1;
    end else if (level_r == LEVEL_ZERO) begin
      tick_dir = 1'b0;
    end else begin
      tick_dir = down_r;
    end
  end

  always_comb begin
    level_nxt   = level_r;
    memo_nxt    = memo_r;
    ramping_nxt = ramping_r;
    down_nxt    = down_r;
    memo_wr     = 1'b0;
    unique case (op)
      OP_TICK: begin
        if (cfg.dimmable && ramping_r) begin
          down_nxt  = tick_dir;
          level_nxt = tick_dir ? dn_lvl : up_lvl;
        end
      end
      OP_TOGGLE: begin
        if (cfg.dimmable) begin
          level_nxt = (level_r != LEVEL_ZERO) ? LEVEL_ZERO : memo_r;
        end else begin
          level_nxt = (level_r == LEVEL_ZERO) ? LEVEL_ONE : LEVEL_ZERO;
        end
      end
      OP_MAX: begin
        if (cfg.dimmable) begin
          level_nxt = LEVEL_MAX;
        end
      end
      OP_DIM_START: begin
        if (cfg.dimmable) begin
          ramping_nxt = 1'b1;
        end
      end
      OP_DIM_STOP: begin
        if (cfg.dimmable) begin
          ramping_nxt = 1'b0;
          memo_nxt    = level_r;
          memo_wr     = 1'b1;
          down_nxt    = ~down_r;
        end
      end
      OP_OFF:       level_nxt = LEVEL_ZERO;
      OP_ON:        level_nxt = cfg.dimmable ? memo_r : LEVEL_ONE;
      OP_SET_LEVEL: level_nxt = operand;
      OP_STORE_MEMO: begin
        memo_nxt = level_r;
        memo_wr  = 1'b1;
      end
      OP_SET_MEMO: begin
        memo_nxt = operand;
        memo_wr  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LEVEL_ZERO;
      memo_r    <= LEVEL_MAX;
      ramping_r <= 1'b0;
      down_r    <= 1'b0;
    end else if (adv) begin
      level_r   <= level_nxt;
      memo_r    <= memo_nxt;
      ramping_r <= ramping_nxt;
      down_r    <= down_nxt;
    end
  end

  assign res.level         = level_nxt;
  assign res.level_changed = (level_nxt != level_r);
  assign res.memo_level    = memo_nxt;
  assign res.memo_written  = memo_wr;

  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !res.level_changed) |=> (level_r == $past(level_r)))
    else $error("level moved without a change flag");

  a_memo_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !res.memo_written) |=> (memo_r == $past(memo_r)))
    else $error("memo moved without a write flag");

  a_onoff_max: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cfg.dimmable && (op == OP_MAX || op == OP_DIM_START || op == OP_DIM_STOP))
    |=> ($stable(level_r) && $stable(memo_r) && $stable(ramping_r)))
    else $error("dimmer command acted in on/off mode");

endmodule

// File: src/ramp_dimmer_with_memory.sv
// Top level of the ramp dimmer with memorised level.
//
// Channels: in_ch takes one command or tick per transaction (opcode, operand);
// out_ch returns exactly one result per command (level, level_changed,
// memo_level, memo_written), in order; cfg_ch writes the lamp mode (index 0)
// and ramp_step (index 1) and is always ready. Write configuration only
// while no command is in flight.
// A command accepted on in_ch is held in the input register; its result is
// computed by the level update logic and captured in the result register,
// from which it is presented on out_ch until taken. The block takes one
// command per cycle while the receiver keeps out_ch ready, set by the single
// register-to-register pass through the level update logic.
// Reset (rst_n low, synchronous) empties both registers, sets level 0,
// memo 255, ramping off, direction up, dimmable mode and a step of 5.
// When the receiver stalls the result register holds, the input register
// still fills, and in_ch.ready drops only once both are occupied.
`timescale 1ns / 1ps
module ramp_dimmer_with_memory
  import rdm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  rdm_in_if.sink    in_ch,
  rdm_out_if.source out_ch,
  rdm_cfg_if.sink   cfg_ch
);

  cfg_t             cfg;
  res_t             res;
  logic             s1_valid_r;
  logic [OP_W-1:0]  s1_op_r;
  logic [LVL_W-1:0] s1_operand_r;
  logic             out_valid_r;
  res_t             out_res_r;
  logic             adv;

  assign adv         = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;

  rdm_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  rdm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .adv     (adv),
    .opcode  (s1_op_r),
    .operand (s1_operand_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r      <= in_ch.opcode;
      s1_operand_r <= in_ch.operand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.level         = out_res_r.level;
  assign out_ch.level_changed = out_res_r.level_changed;
  assign out_ch.memo_level    = out_res_r.memo_level;
  assign out_ch.memo_written  = out_res_r.memo_written;

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with an empty result register");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result lost after advance");

  a_no_adv_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && (!out_valid_r || out_ch.ready)) |=> !out_valid_r)
    else $error("result invented with no command");

endmodule
